// ===== hdl/lgs_pkg.sv =====
// Shared types, constants and the per-row life rule for the grid step unit.
// No dependencies; every other file in hdl/ imports this package.
package lgs_pkg;

    localparam int ROWS    = 32;
    localparam int COLS    = 32;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);
    // generation phase runs 0 .. ROWS+1
    localparam int PHASE_W = $clog2(ROWS + 2);

    localparam logic [3:0] SURVIVE_CNT = 4'd2;
    localparam logic [3:0] BIRTH_CNT   = 4'd3;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_GEN   = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] row;
        logic [4:0] col;
        logic       value;
    } t_item;

    typedef struct packed {
        logic  cell_value;
        t_kind done_kind;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_MODIFY,
        ST_GEN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;     // capture item, clear generation phase and window
        logic access;   // read addressed row
        logic modify;   // write back addressed row with one bit changed
        logic gen_step; // one generation phase
        logic finish;   // launch result transaction
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  gen_last;
    } t_status;

    // Next state of one row from the old rows above, at and below it.
    function automatic logic [COLS-1:0] life_row(input logic [COLS-1:0] above,
                                                 input logic [COLS-1:0] mid,
                                                 input logic [COLS-1:0] below);
        logic [COLS+1:0] a_ext;
        logic [COLS+1:0] m_ext;
        logic [COLS+1:0] b_ext;
        logic [3:0]      n;
        logic [COLS-1:0] res;
        a_ext = {1'b0, above, 1'b0};
        m_ext = {1'b0, mid, 1'b0};
        b_ext = {1'b0, below, 1'b0};
        res   = '0;
        for (int c = 0; c < COLS; c++) begin
            n = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
              + 4'(m_ext[c])                  + 4'(m_ext[c+2])
              + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
            res[c] = (n == BIRTH_CNT) || (mid[c] && (n == SURVIVE_CNT));
        end
        return res;
    endfunction

endpackage

// ===== hdl/life_grid_generation_step_unit.sv =====
// Top level of the bounded-grid Game of Life unit.
// Depends on lgs_pkg, lgs_ctrl and lgs_datapath.
//
// A transaction is taken when start is high and busy is low. Each one gives
// exactly one result, shown on o_result for a single cycle with
// o_result_valid high; the receiver cannot stall it, so it must take it then.
// Write and read of a cell keep busy high through a read of the row and a
// result cycle, plus a write-back of the changed row for a write. A
// generation sweeps the row memory once, one row per cycle through a
// three-row window: an address cycle, the sweep while the window fills and
// drains, and a result cycle; the row memory does one read and one write per
// cycle. Results appear in the first cycle with busy low, and a new
// transaction may start in that same cycle. Reset clears the per-row valid
// bits at once, so the grid reads as all dead with no clearing pass. Cells
// outside the grid read as 0 and ignore writes.
module life_grid_generation_step_unit
    import lgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_result_valid,
    output t_result o_result
);

    t_cmd    w_cmd;
    t_status w_status;

    lgs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    lgs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // a result always follows a busy cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // an accepted transaction keeps the unit busy and emits nothing next cycle
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_valid))
        else $error("accept not followed by busy");

    // only reads return a live cell
    a_cell_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.done_kind != KIND_READ)) |-> !o_result.cell_value)
        else $error("cell value set on a non-read result");

endmodule

// ===== hdl/lgs_ctrl.sv =====
// Controller state machine for the grid step unit.
// Depends on lgs_pkg (state, command and status types).
module lgs_ctrl
    import lgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_cmd.access = 1'b1;
                case (i_status.kind)
                    KIND_GEN:   n_state = ST_GEN;
                    KIND_WRITE: n_state = ST_MODIFY;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state      = ST_DONE;
            end
            ST_GEN: begin
                o_cmd.gen_step = 1'b1;
                if (i_status.gen_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lgs_datapath.sv =====
// Datapath: grid row memory with per-row valid bits, three-row window,
// generation phase counter and result register. Depends on lgs_pkg.
module lgs_datapath
    import lgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output logic    o_result_valid,
    output t_result o_result
);

    // grid storage; rows never written read as dead
    logic [COLS-1:0] r_mem [ROWS];
    logic [ROWS-1:0] r_row_valid;

    t_item             r_item;
    logic [PHASE_W-1:0] r_phase;
    logic [COLS-1:0]   r_above;
    logic [COLS-1:0]   r_mid;
    logic [COLS-1:0]   r_rd_raw;
    logic              r_rd_valid;
    logic              r_res_valid;
    t_result           r_res;

    logic              w_inside;
    logic [ROW_W-1:0]  w_item_row;
    logic [COL_W-1:0]  w_item_col;
    logic [COLS-1:0]   w_rd_row;
    logic [COLS-1:0]   w_mod_row;
    logic [COLS-1:0]   w_below;
    logic [COLS-1:0]   w_new_row;
    logic [PHASE_W-1:0] w_wr_phase;
    logic              w_rd_en;
    logic [ROW_W-1:0]  w_rd_addr;
    logic              w_wr_en;
    logic [ROW_W-1:0]  w_wr_addr;
    logic [COLS-1:0]   w_wr_data;

    assign w_inside   = (32'(r_item.row) < ROWS) && (32'(r_item.col) < COLS);
    assign w_item_row = ROW_W'(r_item.row);
    assign w_item_col = COL_W'(r_item.col);
    assign w_rd_row   = r_rd_valid ? r_rd_raw : '0;

    always_comb begin
        w_mod_row             = w_rd_row;
        w_mod_row[w_item_col] = r_item.value;
    end

    // phase p: issue read of row p, row p-1 is in the read register,
    // compute and store row p-2
    assign w_below    = ((r_phase != '0) && (r_phase <= PHASE_W'(ROWS))) ? w_rd_row : '0;
    assign w_new_row  = life_row(r_above, r_mid, w_below);
    assign w_wr_phase = r_phase - PHASE_W'(2);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_item_row;
        w_wr_en   = 1'b0;
        w_wr_addr = w_item_row;
        w_wr_data = w_mod_row;
        if (i_cmd.access) begin
            w_rd_en = 1'b1;
        end
        if (i_cmd.modify) begin
            w_wr_en = w_inside;
        end
        if (i_cmd.gen_step) begin
            w_rd_en   = (r_phase < PHASE_W'(ROWS));
            w_rd_addr = r_phase[ROW_W-1:0];
            w_wr_en   = (r_phase >= PHASE_W'(2));
            w_wr_addr = w_wr_phase[ROW_W-1:0];
            w_wr_data = w_new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_raw <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_res_valid <= 1'b0;
            r_phase     <= '0;
        end else begin
            if (w_wr_en) begin
                r_row_valid[w_wr_addr] <= 1'b1;
            end
            r_res_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_phase <= '0;
            end else if (i_cmd.gen_step) begin
                r_phase <= r_phase + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_valid <= r_row_valid[w_rd_addr];
        end
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_above <= '0;
            r_mid   <= '0;
        end else if (i_cmd.gen_step) begin
            r_above <= r_mid;
            r_mid   <= w_below;
        end
        if (i_cmd.finish) begin
            r_res.done_kind  <= r_item.kind;
            r_res.cell_value <= (r_item.kind == KIND_READ) && w_inside
                                && w_rd_row[w_item_col];
        end
    end

    assign o_status.kind     = r_item.kind;
    assign o_status.gen_last = (r_phase == PHASE_W'(ROWS + 1));
    assign o_result_valid    = r_res_valid;
    assign o_result          = r_res;

endmodule
